// ===== sv/object_tape_record_parser_defines.svh =====
// Assertion macros shared by the object tape record parser.
// Included by the top level; relies on clk and rst_n in the including scope.
`ifndef OBJECT_TAPE_RECORD_PARSER_DEFINES_SVH
`define OBJECT_TAPE_RECORD_PARSER_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define OTRP_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define OTRP_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== sv/otrp_pkg.sv =====
// Package of the object tape record parser: result type, status codes and constants.
// Used by otrp_core, otrp_out_buf and object_tape_record_parser; no dependencies.
`timescale 1ns / 1ps
`default_nettype none
package otrp_pkg;

  localparam int MAX_DATA_WORDS = 15;

  localparam logic [15:0] LEN_MIN      = 16'(65536 - MAX_DATA_WORDS);
  localparam logic [3:0]  KIND_MAX     = 4'd9;
  localparam logic [3:0]  KIND_RELOC   = 4'd2;
  localparam logic [3:0]  KIND_OBJ_END = 4'd6;
  localparam logic [4:0]  POS_LEN      = 5'd1;
  localparam logic [4:0]  POS_RELOC_LO = 5'd2;
  localparam logic [4:0]  POS_RELOC_HI = 5'd4;
  localparam logic [4:0]  POS_DATA     = 5'd6;
  localparam logic [4:0]  HDR_WORDS    = 5'd6;
  localparam logic [4:0]  LAST_DIGIT   = 5'd14;
  localparam int          RELOC_DIGITS = 15;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_CSUM      = 3'd1,
    ST_PREMATURE = 3'd2,
    ST_END       = 3'd3,
    ST_TOO_LONG  = 3'd4
  } status_t;

  typedef struct packed {
    logic [15:0] word_value;
    logic [4:0]  word_position;
    logic [3:0]  record_kind;
    logic [2:0]  reloc_code;
    logic        record_last;
    logic        object_done;
    status_t     status;
  } result_t;

endpackage
`default_nettype wire

// ===== sv/object_tape_record_parser.sv =====
// Object tape record parser: one tape byte per request in, parsed word results out.
// Top level; depends on otrp_pkg, otrp_core, otrp_out_buf and the assertion macro header.
`timescale 1ns / 1ps
`default_nettype none
`include "object_tape_record_parser_defines.svh"
// The block takes one tape byte or end-of-tape request in every cycle in which in_stall
// is low and needs no warm-up after reset. Every second non-leader byte completes a word;
// its result is written at the same edge to the output register, or to the skid entry
// while the output register still holds a result. The two-entry result buffer between the
// parser and the output asserts in_stall only while both entries hold results, so sustained
// throughput is one byte per cycle whenever the consumer keeps up. After a checksum error,
// a bad type, an oversize length or any end of tape the parser halts and consumes bytes
// without producing results until reset.
module object_tape_record_parser (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [7:0]  in_tape_byte,
  input  wire logic        in_tape_end,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [15:0]      out_word_value,
  output logic [4:0]       out_word_position,
  output logic [3:0]       out_record_kind,
  output logic [2:0]       out_reloc_code,
  output logic             out_record_last,
  output logic             out_object_done,
  output logic [2:0]       out_status
);
  import otrp_pkg::*;

  logic    acc;
  logic    res_valid;
  result_t res;
  result_t out_data;

  assign acc = in_valid && !in_stall;

  otrp_core u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .acc       (acc),
    .tape_byte (in_tape_byte),
    .tape_end  (in_tape_end),
    .res_valid (res_valid),
    .res       (res)
  );

  otrp_out_buf u_out_buf (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (res_valid),
    .push_data (res),
    .full      (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  assign out_word_value    = out_data.word_value;
  assign out_word_position = out_data.word_position;
  assign out_record_kind   = out_data.record_kind;
  assign out_reloc_code    = out_data.reloc_code;
  assign out_record_last   = out_data.record_last;
  assign out_object_done   = out_data.object_done;
  assign out_status        = out_data.status;

  `OTRP_ASSERT_NOW(a_stall_needs_result, !out_valid, !in_stall,
                   "input stalled while no result is pending")
  `OTRP_ASSERT_NOW(a_done_is_clean_end,
                   out_valid && out_object_done,
                   out_record_last && out_status == ST_OK && out_record_kind == KIND_OBJ_END,
                   "object end flagged on a word that is not a clean type 6 final word")
  `OTRP_ASSERT_NOW(a_csum_on_last, out_valid && out_status == ST_CSUM, out_record_last,
                   "checksum error reported away from the final word of a record")
  `OTRP_ASSERT_NEXT(a_push_shows_valid, res_valid, out_valid,
                    "produced result did not reach the output")

endmodule
`default_nettype wire

// ===== sv/otrp_core.sv =====
// Parser state and per-byte step logic of the object tape record parser.
// Depends on otrp_pkg; produces at most one result per accepted byte.
`timescale 1ns / 1ps
`default_nettype none
module otrp_core (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              acc,
  input  wire logic [7:0]        tape_byte,
  input  wire logic              tape_end,
  output logic                   res_valid,
  output otrp_pkg::result_t      res
);
  import otrp_pkg::*;

  typedef enum logic [1:0] {
    PH_TYPE,
    PH_LEN,
    PH_BODY,
    PH_HALT
  } phase_t;

  phase_t                        phase_r, phase_nxt;
  logic                          skip_r, skip_nxt;
  logic                          held_v_r, held_v_nxt;
  logic [7:0]                    held_byte_r, held_byte_nxt;
  logic                          retry_r, retry_nxt;
  logic [4:0]                    wc_r, wc_nxt;
  logic [4:0]                    rw_r, rw_nxt;
  logic [3:0]                    kind_r, kind_nxt;
  logic [RELOC_DIGITS-1:0][2:0]  reloc_r, reloc_nxt;
  logic [15:0]                   sum_r, sum_nxt;

  logic [15:0] w;
  logic [15:0] sum_w;
  logic [4:0]  data_cnt;
  logic [4:0]  digit_k;
  logic [3:0]  digit_sel;
  logic [2:0]  code;
  logic        last_word;
  logic        has_reloc;

  assign w         = {tape_byte, held_byte_r};
  assign sum_w     = sum_r + w;
  assign data_cnt  = 5'(16'd0 - w);
  assign digit_k   = wc_r - POS_DATA;
  assign digit_sel = 4'(LAST_DIGIT - digit_k);
  assign has_reloc = (kind_r == KIND_RELOC) || (kind_r == KIND_OBJ_END);
  assign code      = (has_reloc && wc_r >= POS_DATA && digit_k <= LAST_DIGIT)
                     ? reloc_r[digit_sel] : 3'd0;
  assign last_word = ({1'b0, wc_r} + 6'd1) >= {1'b0, rw_r};

  always_comb begin
    phase_nxt     = phase_r;
    skip_nxt      = skip_r;
    held_v_nxt    = held_v_r;
    held_byte_nxt = held_byte_r;
    retry_nxt     = retry_r;
    wc_nxt        = wc_r;
    rw_nxt        = rw_r;
    kind_nxt      = kind_r;
    reloc_nxt     = reloc_r;
    sum_nxt       = sum_r;
    res_valid     = 1'b0;
    res           = '0;
    if (acc && phase_r != PH_HALT) begin
      if (tape_end) begin
        res_valid = 1'b1;
        phase_nxt = PH_HALT;
        if (phase_r == PH_TYPE) begin
          res.status = ST_END;
        end else begin
          res.status        = ST_PREMATURE;
          res.word_position = wc_r;
          res.record_kind   = kind_r;
        end
      end else if (!held_v_r) begin
        if (!(skip_r && tape_byte == 8'd0)) begin
          skip_nxt      = 1'b0;
          held_v_nxt    = 1'b1;
          held_byte_nxt = tape_byte;
        end
      end else begin
        held_v_nxt = 1'b0;
        case (phase_r)
          PH_TYPE: begin
            if (w == 16'd0 && !retry_r) begin
              retry_nxt = 1'b1;
            end else begin
              retry_nxt      = 1'b0;
              res_valid      = 1'b1;
              res.word_value = w;
              if (w == 16'd0 || w > {12'd0, KIND_MAX}) begin
                res.status = ST_END;
                phase_nxt  = PH_HALT;
              end else begin
                kind_nxt        = w[3:0];
                sum_nxt         = w;
                reloc_nxt       = '0;
                wc_nxt          = POS_LEN;
                phase_nxt       = PH_LEN;
                res.record_kind = w[3:0];
              end
            end
          end
          PH_LEN: begin
            res_valid         = 1'b1;
            res.word_value    = w;
            res.word_position = POS_LEN;
            res.record_kind   = kind_r;
            if (w < LEN_MIN) begin
              res.record_last = 1'b1;
              res.status      = ST_TOO_LONG;
              phase_nxt       = PH_HALT;
            end else begin
              rw_nxt    = HDR_WORDS + data_cnt;
              sum_nxt   = sum_w;
              wc_nxt    = POS_RELOC_LO;
              phase_nxt = PH_BODY;
            end
          end
          PH_BODY: begin
            sum_nxt           = sum_w;
            res_valid         = 1'b1;
            res.word_value    = w;
            res.word_position = wc_r;
            res.record_kind   = kind_r;
            res.reloc_code    = code;
            if (wc_r >= POS_RELOC_LO && wc_r <= POS_RELOC_HI) begin
              reloc_nxt = {reloc_r[RELOC_DIGITS-6:0], w[15:1]};
            end
            if (last_word) begin
              res.record_last = 1'b1;
              if (sum_w != 16'd0) begin
                res.status = ST_CSUM;
                phase_nxt  = PH_HALT;
              end else begin
                if (kind_r == KIND_OBJ_END) begin
                  res.object_done = 1'b1;
                  skip_nxt        = 1'b1;
                end
                phase_nxt = PH_TYPE;
                wc_nxt    = 5'd0;
              end
            end else begin
              wc_nxt = wc_r + 5'd1;
            end
          end
          default: begin
            phase_nxt = PH_HALT;
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= PH_TYPE;
      skip_r   <= 1'b1;
      held_v_r <= 1'b0;
      retry_r  <= 1'b0;
      wc_r     <= '0;
      rw_r     <= '0;
      kind_r   <= '0;
      reloc_r  <= '0;
      sum_r    <= '0;
    end else begin
      phase_r  <= phase_nxt;
      skip_r   <= skip_nxt;
      held_v_r <= held_v_nxt;
      retry_r  <= retry_nxt;
      wc_r     <= wc_nxt;
      rw_r     <= rw_nxt;
      kind_r   <= kind_nxt;
      reloc_r  <= reloc_nxt;
      sum_r    <= sum_nxt;
    end
  end

  always_ff @(posedge clk) begin
    held_byte_r <= held_byte_nxt;
  end

endmodule
`default_nettype wire

// ===== sv/otrp_out_buf.sv =====
// Two-entry result buffer (output register plus skid register) for the parser.
// Depends on otrp_pkg; its stall toward the core is taken straight from a register.
`timescale 1ns / 1ps
`default_nettype none
module otrp_out_buf (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              push,
  input  wire otrp_pkg::result_t push_data,
  output logic                   full,
  output logic                   out_valid,
  input  wire logic              out_stall,
  output otrp_pkg::result_t      out_data
);
  import otrp_pkg::*;

  logic    main_v_r, main_v_nxt;
  logic    skid_v_r, skid_v_nxt;
  result_t main_r, main_nxt;
  result_t skid_r, skid_nxt;
  logic    pop;

  assign pop       = main_v_r && !out_stall;
  assign full      = skid_v_r;
  assign out_valid = main_v_r;
  assign out_data  = main_r;

  always_comb begin
    main_v_nxt = main_v_r;
    skid_v_nxt = skid_v_r;
    main_nxt   = main_r;
    skid_nxt   = skid_r;
    if (skid_v_r) begin
      if (pop) begin
        main_nxt   = skid_r;
        skid_v_nxt = 1'b0;
      end
    end else if (push) begin
      if (!main_v_r || pop) begin
        main_nxt   = push_data;
        main_v_nxt = 1'b1;
      end else begin
        skid_nxt   = push_data;
        skid_v_nxt = 1'b1;
      end
    end else if (pop) begin
      main_v_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      main_v_r <= 1'b0;
      skid_v_r <= 1'b0;
    end else begin
      main_v_r <= main_v_nxt;
      skid_v_r <= skid_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    main_r <= main_nxt;
    skid_r <= skid_nxt;
  end

endmodule
`default_nettype wire

// ===== tb/testbench.sv =====
// Self-checking testbench for object_tape_record_parser: tape byte streams in, parsed words out.
// Needs otrp_pkg and the parser RTL; predicts every result on its own and compares each field.
`timescale 1ns / 1ps
module testbench;
  import otrp_pkg::*;

  localparam int CYCLE_LIMIT = 500000;
  localparam int RANDOM_BYTES = 620;
  localparam int HOLD_AFTER = 100;
  localparam int HOLD_CYCLES = 300;
  localparam int DRAIN_CYCLES = 20;

  typedef enum logic [1:0] {P_TYPE, P_LEN, P_BODY, P_HALT} parse_phase_t;

  typedef struct packed {
    logic [7:0] tape_byte;
    logic       tape_end;
  } tape_req_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [7:0]  in_tape_byte = 8'h00;
  logic        in_tape_end = 1'b0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [15:0] out_word_value;
  logic [4:0]  out_word_position;
  logic [3:0]  out_record_kind;
  logic [2:0]  out_reloc_code;
  logic        out_record_last;
  logic        out_object_done;
  logic [2:0]  out_status;

  tape_req_t tape_queue[$];
  result_t   expected_words[$];
  int        fail_count = 0;
  int        cycle_count = 0;
  int        results_seen = 0;
  int        hold_left = 0;
  bit        hold_done = 1'b0;
  int        gap_left = 0;
  int        stall_left = 0;
  bit        quiet_in = 1'b0;
  bit        quiet_out = 1'b0;
  bit        leader_ok = 1'b1;

  parse_phase_t phase_now = P_TYPE;
  bit           skip_zero = 1'b1;
  bit           held_ok = 1'b0;
  logic [7:0]   held_byte = 8'h00;
  bit           retry_pending = 1'b0;
  logic [4:0]   word_idx = 5'd0;
  logic [4:0]   rec_len = 5'd0;
  logic [3:0]   rec_kind_now = 4'd0;
  logic [44:0]  reloc_bits = 45'd0;
  logic [15:0]  word_sum = 16'd0;

  object_tape_record_parser i_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_tape_byte     (in_tape_byte),
    .in_tape_end      (in_tape_end),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_word_value   (out_word_value),
    .out_word_position(out_word_position),
    .out_record_kind  (out_record_kind),
    .out_reloc_code   (out_reloc_code),
    .out_record_last  (out_record_last),
    .out_object_done  (out_object_done),
    .out_status       (out_status)
  );

  always #5 clk = ~clk;

  function automatic int pick_gap();
    int r;
    r = $urandom_range(99, 0);
    if (r < 70) return 0;
    if (r < 97) return $urandom_range(3, 1);
    return $urandom_range(40, 10);
  endfunction

  task automatic parse_tape_byte(input logic [7:0] b, input logic e);
    logic [15:0] w;
    logic [15:0] ndata;
    logic [4:0]  pos;
    result_t     r;
    if (phase_now == P_HALT) return;
    r = '0;
    if (e) begin
      if (phase_now == P_TYPE) begin
        r.status = ST_END;
      end else begin
        r.status = ST_PREMATURE;
        r.word_position = word_idx;
        r.record_kind = rec_kind_now;
      end
      expected_words.push_back(r);
      phase_now = P_HALT;
      return;
    end
    if (!held_ok) begin
      if (skip_zero && b == 8'h00) return;
      skip_zero = 1'b0;
      held_ok = 1'b1;
      held_byte = b;
      return;
    end
    w = {b, held_byte};
    held_ok = 1'b0;
    r.word_value = w;
    case (phase_now)
      P_TYPE: begin
        if (w == 16'h0000 && !retry_pending) begin
          retry_pending = 1'b1;
          return;
        end
        retry_pending = 1'b0;
        if (w == 16'h0000 || w > KIND_MAX) begin
          r.status = ST_END;
          phase_now = P_HALT;
        end else begin
          rec_kind_now = w[3:0];
          word_sum = w;
          reloc_bits = '0;
          word_idx = 5'd1;
          phase_now = P_LEN;
          r.record_kind = rec_kind_now;
        end
      end
      P_LEN: begin
        ndata = 16'h0000 - w;
        r.word_position = POS_LEN;
        r.record_kind = rec_kind_now;
        if (w == 16'h0000 || ndata > MAX_DATA_WORDS) begin
          r.status = ST_TOO_LONG;
          r.record_last = 1'b1;
          phase_now = P_HALT;
        end else begin
          rec_len = HDR_WORDS + ndata[4:0];
          word_sum = word_sum + w;
          word_idx = 5'd2;
          phase_now = P_BODY;
        end
      end
      default: begin
        pos = word_idx;
        word_sum = word_sum + w;
        if (pos >= POS_RELOC_LO && pos <= POS_RELOC_HI)
          reloc_bits = {reloc_bits[29:0], w[15:1]};
        r.word_position = pos;
        r.record_kind = rec_kind_now;
        if (pos >= POS_DATA && (rec_kind_now == KIND_RELOC || rec_kind_now == KIND_OBJ_END))
          r.reloc_code = 3'(reloc_bits >> (3 * (LAST_DIGIT - (pos - POS_DATA))));
        if (pos + 5'd1 >= rec_len) begin
          r.record_last = 1'b1;
          if (word_sum != 16'h0000) begin
            r.status = ST_CSUM;
            phase_now = P_HALT;
          end else begin
            if (rec_kind_now == KIND_OBJ_END) begin
              r.object_done = 1'b1;
              skip_zero = 1'b1;
            end
            phase_now = P_TYPE;
            word_idx = 5'd0;
          end
        end else begin
          word_idx = pos + 5'd1;
        end
      end
    endcase
    expected_words.push_back(r);
  endtask

  task automatic report_failure(input string what, input result_t want, input result_t got);
    fail_count++;
    if (fail_count <= 10) begin
      $display("%s: want value %h pos %0d kind %0d reloc %0d last %b done %b status %0d",
               what, want.word_value, want.word_position, want.record_kind, want.reloc_code,
               want.record_last, want.object_done, want.status);
      $display("%s: got  value %h pos %0d kind %0d reloc %0d last %b done %b status %0d",
               what, got.word_value, got.word_position, got.record_kind, got.reloc_code,
               got.record_last, got.object_done, got.status);
    end
  endtask

  task automatic push_byte(input logic [7:0] b, input logic e);
    tape_req_t req;
    req.tape_byte = b;
    req.tape_end = e;
    tape_queue.push_back(req);
  endtask

  task automatic push_word(input logic [15:0] w);
    push_byte(w[7:0], 1'b0);
    push_byte(w[15:8], 1'b0);
  endtask

  task automatic queue_leader(input int count);
    repeat (count) push_byte(8'h00, 1'b0);
  endtask

  // fill: 0 random words, 1 all ones, 2 all zeros. cut_at >= 0 ends the tape at that word.
  task automatic queue_record(input logic [3:0] kind, input int ndata, input int fill,
                              input bit bad_sum, input int cut_at);
    logic [15:0] words[$];
    logic [15:0] acc;
    int          i;
    words.push_back({12'h000, kind});
    words.push_back(16'(65536 - ndata));
    for (i = 0; i < 4 + ndata; i++)
      words.push_back((i == 3) ? 16'h0000 : (fill == 1) ? 16'hFFFF :
                      (fill == 2) ? 16'h0000 : 16'($urandom));
    acc = 16'h0000;
    foreach (words[j]) acc = acc + words[j];
    words[5] = 16'h0000 - acc + 16'(bad_sum);
    for (i = 0; i < words.size(); i++) begin
      if (i == cut_at) begin
        if ($urandom_range(1, 0)) push_byte(words[i][7:0], 1'b0);
        push_byte(8'($urandom), 1'b1);
        return;
      end
      push_word(words[i]);
    end
    leader_ok = (kind == KIND_OBJ_END) && !bad_sum;
  endtask

  always @(posedge clk) begin : drive_tape
    tape_req_t req;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) parse_tape_byte(in_tape_byte, in_tape_end);
      if (!in_valid || !in_stall) begin
        if (gap_left > 0) begin
          gap_left--;
          in_valid <= 1'b0;
        end else if (tape_queue.size() != 0) begin
          req = tape_queue.pop_front();
          in_valid <= 1'b1;
          in_tape_byte <= req.tape_byte;
          in_tape_end <= req.tape_end;
          if ($urandom_range(63, 0) == 0) quiet_in = !quiet_in;
          gap_left = quiet_in ? 0 : pick_gap();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      hold_left <= 0;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
    end else if (!hold_done && results_seen >= HOLD_AFTER) begin
      hold_left <= HOLD_CYCLES;
      hold_done <= 1'b1;
    end
  end

  always @(posedge clk) begin : watch_results
    result_t got;
    result_t want;
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        got.word_value = out_word_value;
        got.word_position = out_word_position;
        got.record_kind = out_record_kind;
        got.reloc_code = out_reloc_code;
        got.record_last = out_record_last;
        got.object_done = out_object_done;
        got.status = status_t'(out_status);
        results_seen <= results_seen + 1;
        if (expected_words.size() == 0) begin
          report_failure("unexpected result", '0, got);
        end else begin
          want = expected_words.pop_front();
          if (got.word_value !== want.word_value || got.word_position !== want.word_position ||
              got.record_kind !== want.record_kind || got.reloc_code !== want.reloc_code ||
              got.record_last !== want.record_last || got.object_done !== want.object_done ||
              got.status !== want.status)
            report_failure("mismatch", want, got);
        end
      end
      if ($urandom_range(127, 0) == 0) quiet_out = !quiet_out;
      if (stall_left > 0) stall_left--;
      else stall_left = quiet_out ? 0 : pick_gap();
      out_stall <= (hold_left > 0) || (stall_left != 0);
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  initial begin
    int          start;
    int          pick;
    int          nd;
    logic [3:0]  k;
    logic [15:0] w;

    queue_leader(3);
    queue_record(KIND_RELOC, MAX_DATA_WORDS, 1, 1'b0, -1);
    push_word(16'h0000);
    queue_record(KIND_MAX, 1, 2, 1'b0, -1);
    queue_record(KIND_OBJ_END, MAX_DATA_WORDS, 0, 1'b0, -1);
    queue_leader(2);
    queue_record(4'd1, 1, 1, 1'b0, -1);
    queue_record(KIND_OBJ_END, 1, 2, 1'b0, -1);

    start = tape_queue.size();
    while (tape_queue.size() < start + RANDOM_BYTES) begin
      if (leader_ok && $urandom_range(1, 0)) queue_leader($urandom_range(6, 1));
      else if (!leader_ok && $urandom_range(7, 0) == 0) push_word(16'h0000);
      pick = $urandom_range(11, 0);
      k = (pick < 4) ? KIND_RELOC : (pick < 7) ? KIND_OBJ_END : 4'($urandom_range(9, 1));
      queue_record(k, $urandom_range(MAX_DATA_WORDS, 1),
                   ($urandom_range(19, 0) == 0) ? $urandom_range(2, 1) : 0, 1'b0, -1);
    end

    // The run closes with one randomly chosen way of stopping the parser.
    k = 4'($urandom_range(9, 1));
    nd = $urandom_range(MAX_DATA_WORDS, 1);
    case ($urandom_range(5, 0))
      0: begin
        if ($urandom_range(1, 0)) push_byte(8'($urandom_range(255, 1)), 1'b0);
        push_byte(8'($urandom), 1'b1);
      end
      1: queue_record(k, nd, 0, 1'b0, $urandom_range(5 + nd, 1));
      2: begin
        w = 16'($urandom_range(65535, 10));
        if (w[7:0] == 8'h00) w[0] = 1'b1;
        push_word(w);
      end
      3: begin
        if (leader_ok) queue_record(4'($urandom_range(5, 1)), nd, 0, 1'b0, -1);
        push_word(16'h0000);
        push_word(16'h0000);
      end
      4: begin
        push_word({12'h000, k});
        push_word(($urandom_range(3, 0) == 0) ? 16'h0000 :
                  16'($urandom_range(65535 - MAX_DATA_WORDS, 1)));
      end
      default: queue_record(k, nd, 0, 1'b1, -1);
    endcase
    repeat (20) push_byte(8'($urandom), 1'($urandom));

    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    while (tape_queue.size() != 0 || in_valid || expected_words.size() != 0)
      @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    while (expected_words.size() != 0)
      report_failure("missing result", expected_words.pop_front(), '0);
    if (fail_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end
endmodule

// ===== object_tape_record_parser.f =====
+incdir+sv
sv/otrp_pkg.sv
sv/otrp_core.sv
sv/otrp_out_buf.sv
sv/object_tape_record_parser.sv
tb/testbench.sv
